@@ src/trmt_pkg.sv @@
// shared constants, codes and types of the tape record memory transfer block
package trmt_pkg;

    // widths
    localparam int ADDR_BITS_DEF = 14;
    localparam int ADDR_MAX      = 16;
    localparam int MEM_SIZE_W    = 15;
    localparam int CHAR_W        = 6;
    localparam int WORD_W        = 7;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 3;
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 32;
    localparam int REG_IDX_W     = 3;
    localparam int QUEUE_DEPTH   = 2;

    // item commands
    localparam logic [CMD_W-1:0] CMD_START_READ  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TAPE_CHAR   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_END_RECORD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MEM_WORD    = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_CONTINUE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_GROUP_MARK  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WRAP        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY_WRITE = 3'd4;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_MEMORY_SIZE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TAPE_MARK   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GROUP_MARK  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WORD_MARK   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ALT_BLANK   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BLANK       = 3'd5;

    // register reset values
    localparam logic [MEM_SIZE_W-1:0] MEM_SIZE_RST   = 15'd16000;
    localparam logic [CHAR_W-1:0]     TAPE_MARK_RST  = 6'd15;
    localparam logic [CHAR_W-1:0]     GROUP_MARK_RST = 6'd63;
    localparam logic [CHAR_W-1:0]     WORD_MARK_RST  = 6'd29;
    localparam logic [CHAR_W-1:0]     ALT_BLANK_RST  = 6'd16;
    localparam logic [CHAR_W-1:0]     BLANK_RST      = 6'd0;

    // mode bit positions
    localparam int MODE_BIN  = 0;
    localparam int MODE_WM   = 1;
    localparam int MODE_BOOT = 2;

    typedef struct packed {
        logic [MEM_SIZE_W-1:0] memory_size;
        logic [CHAR_W-1:0]     tape_mark_code;
        logic [CHAR_W-1:0]     group_mark_code;
        logic [CHAR_W-1:0]     word_mark_code;
        logic [CHAR_W-1:0]     alt_blank_code;
        logic [CHAR_W-1:0]     blank_code;
    } cfg_t;

    // one result; the address is held zero-extended to the widest build
    typedef struct packed {
        logic                mem_write;
        logic [ADDR_MAX-1:0] mem_addr;
        logic [WORD_W-1:0]   mem_data;
        logic                tape_valid;
        logic [CHAR_W-1:0]   tape_out;
        logic [STATUS_W-1:0] status;
        logic                end_ind;
        logic                err_ind;
        logic                last;
    } res_t;

    // one decoded item: one or two results
    typedef struct packed {
        res_t res_a;
        res_t res_b;
        logic two;
    } rec_t;

endpackage

@@ src/trmt_cfg.sv @@
// configuration registers behind the apb-style port
module trmt_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [trmt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [trmt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [trmt_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output trmt_pkg::cfg_t                  cfg
);
    import trmt_pkg::*;

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.memory_size     <= MEM_SIZE_RST;
            cfg_reg.tape_mark_code  <= TAPE_MARK_RST;
            cfg_reg.group_mark_code <= GROUP_MARK_RST;
            cfg_reg.word_mark_code  <= WORD_MARK_RST;
            cfg_reg.alt_blank_code  <= ALT_BLANK_RST;
            cfg_reg.blank_code      <= BLANK_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MEMORY_SIZE: cfg_reg.memory_size     <= pwdata[MEM_SIZE_W-1:0];
                REG_TAPE_MARK:   cfg_reg.tape_mark_code  <= pwdata[CHAR_W-1:0];
                REG_GROUP_MARK:  cfg_reg.group_mark_code <= pwdata[CHAR_W-1:0];
                REG_WORD_MARK:   cfg_reg.word_mark_code  <= pwdata[CHAR_W-1:0];
                REG_ALT_BLANK:   cfg_reg.alt_blank_code  <= pwdata[CHAR_W-1:0];
                REG_BLANK:       cfg_reg.blank_code      <= pwdata[CHAR_W-1:0];
                default:         ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_MEMORY_SIZE: prdata = APB_DATA_W'(cfg_reg.memory_size);
            REG_TAPE_MARK:   prdata = APB_DATA_W'(cfg_reg.tape_mark_code);
            REG_GROUP_MARK:  prdata = APB_DATA_W'(cfg_reg.group_mark_code);
            REG_WORD_MARK:   prdata = APB_DATA_W'(cfg_reg.word_mark_code);
            REG_ALT_BLANK:   prdata = APB_DATA_W'(cfg_reg.alt_blank_code);
            REG_BLANK:       prdata = APB_DATA_W'(cfg_reg.blank_code);
            default:         prdata = '0;
        endcase
    end

endmodule

@@ src/trmt_front.sv @@
// front end: takes items, keeps the transfer state and decodes each item into results
module trmt_front #(
    parameter int ADDR_BITS = trmt_pkg::ADDR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  trmt_pkg::cfg_t                cfg,
    input  logic                          accept,
    input  logic [trmt_pkg::CMD_W-1:0]    cmd,
    input  logic                          binary_mode,
    input  logic                          word_mark_mode,
    input  logic                          boot_mode,
    input  logic [ADDR_BITS-1:0]          start_address,
    input  logic                          record_is_tape_mark,
    input  logic                          record_in_error,
    input  logic [trmt_pkg::WORD_W-1:0]   tape_char,
    input  logic [trmt_pkg::WORD_W-1:0]   mem_word,
    output trmt_pkg::rec_t                rec
);
    import trmt_pkg::*;

    localparam int SW = (ADDR_BITS + 1 > MEM_SIZE_W) ? ADDR_BITS + 1 : MEM_SIZE_W;

    // transfer state
    logic [ADDR_BITS-1:0] address_reg, address_next;
    logic                 wm_pending_reg, wm_pending_next;
    logic                 first_char_reg, first_char_next;
    logic [2:0]           modes_reg, modes_next;
    logic                 tm_record_reg, tm_record_next;
    logic                 active_reg, active_next;
    logic                 writing_reg, writing_next;
    logic                 end_flag_reg, end_flag_next;
    logic                 error_flag_reg, error_flag_next;

    // address arithmetic
    logic [SW-1:0]        mem_size_ext, addr_limit, size_used, addr_inc;
    logic                 wrap;
    logic [ADDR_BITS-1:0] addr_step;
    logic                 mem_is_gmwm;
    logic                 bin, wmm, boot;

    assign mem_size_ext = SW'(cfg.memory_size);
    assign addr_limit   = SW'(1) << ADDR_BITS;
    assign addr_inc     = SW'(address_reg) + SW'(1);
    assign wrap         = addr_inc >= size_used;
    assign addr_step    = wrap ? '0 : addr_inc[ADDR_BITS-1:0];
    assign mem_is_gmwm  = mem_word == {1'b1, cfg.group_mark_code};
    assign bin          = modes_reg[MODE_BIN];
    assign wmm          = modes_reg[MODE_WM];
    assign boot         = modes_reg[MODE_BOOT];

    // memory size limited to one up to the address space
    always_comb
    begin
        if (mem_size_ext == '0)
            size_used = SW'(1);
        else if (mem_size_ext > addr_limit)
            size_used = addr_limit;
        else
            size_used = mem_size_ext;
    end

    // item decode
    res_t              pre, fin;
    logic              two;
    logic [CHAR_W-1:0] raw, tch;
    logic              wr;
    logic [WORD_W-1:0] dat;
    logic [STATUS_W-1:0] st;

    always_comb
    begin
        address_next    = address_reg;
        wm_pending_next = wm_pending_reg;
        first_char_next = first_char_reg;
        modes_next      = modes_reg;
        tm_record_next  = tm_record_reg;
        active_next     = active_reg;
        writing_next    = writing_reg;
        end_flag_next   = end_flag_reg;
        error_flag_next = error_flag_reg;
        pre             = '0;
        fin             = '0;
        two             = 1'b0;
        raw             = tape_char[CHAR_W-1:0];
        tch             = raw;
        wr              = 1'b0;
        dat             = '0;
        st              = ST_CONTINUE;

        if (cmd == CMD_START_READ || cmd == CMD_START_WRITE)
        begin
            // start of a transfer
            modes_next      = {boot_mode, word_mark_mode, binary_mode};
            address_next    = start_address;
            first_char_next = 1'b1;
            wm_pending_next = 1'b0;
            active_next     = 1'b1;
            writing_next    = cmd == CMD_START_WRITE;
            if (cmd == CMD_START_READ)
            begin
                tm_record_next  = record_is_tape_mark;
                end_flag_next   = record_is_tape_mark;
                error_flag_next = record_in_error;
            end
            else
            begin
                tm_record_next  = 1'b0;
                end_flag_next   = 1'b0;
                error_flag_next = 1'b0;
            end
            if (SW'(start_address) >= size_used)
            begin
                address_next = '0;
                active_next  = 1'b0;
                st           = ST_WRAP;
            end
            fin.mem_addr = ADDR_MAX'(address_next);
        end
        else if (cmd == CMD_TAPE_CHAR && active_reg && !writing_reg)
        begin
            // tape character into memory
            if (first_char_reg && !bin && raw == cfg.tape_mark_code)
                end_flag_next = 1'b1;
            first_char_next = 1'b0;
            if (!boot && mem_is_gmwm)
            begin
                address_next = addr_step;
                st           = wrap ? ST_WRAP : ST_GROUP_MARK;
                active_next  = 1'b0;
                fin.mem_addr = ADDR_MAX'(addr_step);
            end
            else
            begin
                if (!bin && raw == cfg.alt_blank_code)
                    tch = cfg.blank_code;
                if (wmm)
                begin
                    if (tch == cfg.word_mark_code && !wm_pending_reg)
                        wm_pending_next = 1'b1;
                    else
                    begin
                        wr              = 1'b1;
                        dat             = {wm_pending_reg, tch};
                        wm_pending_next = 1'b0;
                    end
                end
                else
                begin
                    wr  = 1'b1;
                    dat = {mem_word[WORD_W-1], tch};
                end
                if (!wm_pending_next)
                begin
                    address_next = addr_step;
                    if (wrap)
                    begin
                        st          = ST_WRAP;
                        active_next = 1'b0;
                    end
                end
                fin.mem_write = wr;
                fin.mem_data  = dat;
                fin.mem_addr  = wr ? ADDR_MAX'(address_reg) : ADDR_MAX'(address_next);
            end
        end
        else if (cmd == CMD_END_RECORD && active_reg && !writing_reg)
        begin
            // end of record: closing group mark unless a tape mark record
            active_next = 1'b0;
            if (tm_record_reg)
            begin
                st           = ST_DONE;
                fin.mem_addr = ADDR_MAX'(address_reg);
            end
            else
            begin
                if (!mem_is_gmwm)
                begin
                    wr  = 1'b1;
                    dat = wmm ? {1'b0, cfg.group_mark_code}
                              : {mem_word[WORD_W-1], cfg.group_mark_code};
                end
                address_next  = addr_step;
                st            = wrap ? ST_WRAP : ST_DONE;
                fin.mem_write = wr;
                fin.mem_data  = dat;
                fin.mem_addr  = wr ? ADDR_MAX'(address_reg) : ADDR_MAX'(addr_step);
            end
        end
        else if (cmd == CMD_MEM_WORD && active_reg && writing_reg)
        begin
            // memory word onto tape
            first_char_next = 1'b0;
            if (mem_is_gmwm)
            begin
                active_next = 1'b0;
                if (first_char_reg)
                    st = ST_EMPTY_WRITE;
                else
                begin
                    address_next = addr_step;
                    st           = wrap ? ST_WRAP : ST_DONE;
                end
                fin.mem_addr = ADDR_MAX'(address_next);
            end
            else
            begin
                if (mem_word[WORD_W-1] && wmm)
                begin
                    two            = 1'b1;
                    pre.mem_addr   = ADDR_MAX'(address_reg);
                    pre.tape_valid = 1'b1;
                    pre.tape_out   = cfg.word_mark_code;
                end
                tch = mem_word[CHAR_W-1:0];
                if (tch == cfg.blank_code && !bin)
                    tch = cfg.alt_blank_code;
                address_next = addr_step;
                if (wrap)
                begin
                    st          = ST_WRAP;
                    active_next = 1'b0;
                end
                fin.mem_addr   = ADDR_MAX'(addr_step);
                fin.tape_valid = 1'b1;
                fin.tape_out   = tch;
            end
        end
        else
        begin
            // idle, wrong direction or unknown command
            fin.mem_addr = ADDR_MAX'(address_reg);
        end

        fin.status  = st;
        fin.last    = 1'b1;
        fin.end_ind = end_flag_next;
        fin.err_ind = error_flag_next;
        pre.status  = ST_CONTINUE;
        pre.last    = 1'b0;
        pre.end_ind = end_flag_next;
        pre.err_ind = error_flag_next;
    end

    assign rec.res_a = two ? pre : fin;
    assign rec.res_b = fin;
    assign rec.two   = two;

    // state update on each transfer in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg    <= '0;
            wm_pending_reg <= 1'b0;
            first_char_reg <= 1'b1;
            modes_reg      <= '0;
            tm_record_reg  <= 1'b0;
            active_reg     <= 1'b0;
            writing_reg    <= 1'b0;
            end_flag_reg   <= 1'b0;
            error_flag_reg <= 1'b0;
        end
        else if (accept)
        begin
            address_reg    <= address_next;
            wm_pending_reg <= wm_pending_next;
            first_char_reg <= first_char_next;
            modes_reg      <= modes_next;
            tm_record_reg  <= tm_record_next;
            active_reg     <= active_next;
            writing_reg    <= writing_next;
            end_flag_reg   <= end_flag_next;
            error_flag_reg <= error_flag_next;
        end
    end

endmodule

@@ src/trmt_queue.sv @@
// short queue of decoded items between front and back ends
module trmt_queue #(
    parameter int DEPTH = trmt_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  trmt_pkg::rec_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output trmt_pkg::rec_t rd_data,
    output logic           empty
);
    import trmt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rec_t          entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries_reg[wr_ptr_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

@@ src/trmt_back.sv @@
// back end: plays out the one or two results of each item through the output register
module trmt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  trmt_pkg::rec_t q_data,
    input  logic           q_empty,
    output logic           q_pop,
    input  logic           pop,
    output logic           empty,
    output trmt_pkg::res_t out_res
);
    import trmt_pkg::*;

    rec_t cur_reg;
    logic cur_valid_reg;
    logic second_reg;
    logic fire, done, load;

    assign empty   = !cur_valid_reg;
    assign out_res = second_reg ? cur_reg.res_b : cur_reg.res_a;
    assign fire    = pop && cur_valid_reg;
    assign done    = fire && (second_reg || !cur_reg.two);
    assign load    = !cur_valid_reg || done;
    assign q_pop   = load && !q_empty;

    // current item payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
    end

    // output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else if (load)
        begin
            cur_valid_reg <= !q_empty;
            second_reg    <= 1'b0;
        end
        else if (fire)
        begin
            second_reg <= 1'b1;
        end
    end

endmodule

@@ src/tape_record_memory_transfer_top.sv @@
// top level of the tape record memory transfer block
//
// Moves characters between a seven-track tape record and a word-marked
// character memory. Items come in on a queue-style port (push, full): an
// item is taken at a clock edge with push high and full low. Results leave
// on a queue-style port (empty, pop): the oldest result sits on the result
// ports while empty is low and is taken at an edge with pop high.
// Registers sit behind an apb-style port at byte address 4*index, pready
// always high; they are to be written only while no transfer is in flight,
// which the block itself does not enforce. Results pass through the decode
// queue and then the output register. Throughput: one item per cycle on the
// input side while the two-entry decode queue has room; the result side
// gives one result per cycle while pop is high, so a memory word that emits
// a word-mark character as well gives two results. When pop stays low the
// output register holds, the decode queue fills and full rises; the front
// keeps its state until the next transfer in. Reset clears the transfer
// state, empties both stages and loads the register defaults.
module tape_record_memory_transfer_top #(
    parameter int ADDR_BITS = trmt_pkg::ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [trmt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [trmt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [trmt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic [trmt_pkg::CMD_W-1:0]        cmd,
    input  logic                              binary_mode,
    input  logic                              word_mark_mode,
    input  logic                              boot_mode,
    input  logic [ADDR_BITS-1:0]              start_address,
    input  logic                              record_is_tape_mark,
    input  logic                              record_in_error,
    input  logic [trmt_pkg::WORD_W-1:0]       tape_char,
    input  logic [trmt_pkg::WORD_W-1:0]       mem_word,
    output logic                              empty,
    input  logic                              pop,
    output logic                              mem_write,
    output logic [ADDR_BITS-1:0]              mem_addr,
    output logic [trmt_pkg::WORD_W-1:0]       mem_data,
    output logic                              tape_valid,
    output logic [trmt_pkg::CHAR_W-1:0]       tape_out,
    output logic [trmt_pkg::STATUS_W-1:0]     status,
    output logic                              end_indicator,
    output logic                              error_indicator,
    output logic                              last
);
    import trmt_pkg::*;

    cfg_t cfg;
    rec_t rec, q_data;
    res_t out_res;
    logic accept, q_empty, q_pop;

    assign accept = push && !full;

    // configuration registers
    trmt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front end
    trmt_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg),
        .accept              (accept),
        .cmd                 (cmd),
        .binary_mode         (binary_mode),
        .word_mark_mode      (word_mark_mode),
        .boot_mode           (boot_mode),
        .start_address       (start_address),
        .record_is_tape_mark (record_is_tape_mark),
        .record_in_error     (record_in_error),
        .tape_char           (tape_char),
        .mem_word            (mem_word),
        .rec                 (rec)
    );

    // decode queue
    trmt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (rec),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    // back end
    trmt_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .out_res (out_res)
    );

    // result fields
    assign mem_write       = out_res.mem_write;
    assign mem_addr        = out_res.mem_addr[ADDR_BITS-1:0];
    assign mem_data        = out_res.mem_data;
    assign tape_valid      = out_res.tape_valid;
    assign tape_out        = out_res.tape_out;
    assign status          = out_res.status;
    assign end_indicator   = out_res.end_ind;
    assign error_indicator = out_res.err_ind;
    assign last            = out_res.last;

endmodule

@@ src/trmt_checker.sv @@
// port-level checks of the tape record memory transfer block, bound to the top level
module trmt_checker #(
    parameter int ADDR_BITS = trmt_pkg::ADDR_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic                          mem_write,
    input logic [ADDR_BITS-1:0]          mem_addr,
    input logic [trmt_pkg::WORD_W-1:0]   mem_data,
    input logic                          tape_valid,
    input logic [trmt_pkg::CHAR_W-1:0]   tape_out,
    input logic [trmt_pkg::STATUS_W-1:0] status,
    input logic                          end_indicator,
    input logic                          error_indicator,
    input logic                          last
);
    import trmt_pkg::*;

    // a waiting result holds while not taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable({mem_write, mem_addr, mem_data, tape_valid,
            tape_out, status, end_indicator, error_indicator, last}))
        else $error("result changed while stalled");

    // a result never both stores and emits, and unused data is zero
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(mem_write && tape_valid) && (mem_write || mem_data == '0)
            && (tape_valid || tape_out == '0))
        else $error("result carries inconsistent payload");

    // the first of a pair is a word-mark tape character with continue status
    a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !last |-> tape_valid && !mem_write && status == ST_CONTINUE)
        else $error("non-last result is not a word-mark character");

    // the second of a pair follows at once
    a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !last && pop |=> !empty && last && tape_valid)
        else $error("second result of a pair missing");

endmodule

bind tape_record_memory_transfer_top trmt_checker #(
    .ADDR_BITS (ADDR_BITS)
) u_trmt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .pop             (pop),
    .mem_write       (mem_write),
    .mem_addr        (mem_addr),
    .mem_data        (mem_data),
    .tape_valid      (tape_valid),
    .tape_out        (tape_out),
    .status          (status),
    .end_indicator   (end_indicator),
    .error_indicator (error_indicator),
    .last            (last)
);

@@ dv/tb_tape_record_memory_transfer_top.sv @@
// self-checking testbench for the tape record memory transfer block
module tb_tape_record_memory_transfer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import trmt_pkg::*;

    localparam int ADDR_BITS       = ADDR_BITS_DEF;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RECORD_ITEMS    = 230;
    localparam int SEGMENTS        = 9;

    // commands with no meaning, ignored by the block
    localparam logic [CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic                 binary_mode;
        logic                 word_mark_mode;
        logic                 boot_mode;
        logic [ADDR_BITS-1:0] start_address;
        logic                 record_is_tape_mark;
        logic                 record_in_error;
        logic [WORD_W-1:0]    tape_char;
        logic [WORD_W-1:0]    mem_word;
    } transfer_item_t;

    // tracks registers and transfer state, holds the results still owed by the block
    class char_transfer_tracker;
        logic [MEM_SIZE_W-1:0] memory_size;
        logic [CHAR_W-1:0]     tape_mark_code;
        logic [CHAR_W-1:0]     group_mark_code;
        logic [CHAR_W-1:0]     word_mark_code;
        logic [CHAR_W-1:0]     alt_blank_code;
        logic [CHAR_W-1:0]     blank_code;
        logic [ADDR_BITS-1:0]  address;
        bit                    mark_pending;
        bit                    first_char;
        bit                    binary;
        bit                    mark_mode;
        bit                    boot;
        bit                    tape_mark_record;
        bit                    active;
        bit                    writing;
        bit                    end_flag;
        bit                    error_flag;
        res_t                  awaited[$];
        int unsigned           failures;

        function new();
            memory_size     = MEM_SIZE_RST;
            tape_mark_code  = TAPE_MARK_RST;
            group_mark_code = GROUP_MARK_RST;
            word_mark_code  = WORD_MARK_RST;
            alt_blank_code  = ALT_BLANK_RST;
            blank_code      = BLANK_RST;
            address         = '0;
            mark_pending    = 1'b0;
            first_char      = 1'b1;
            binary          = 1'b0;
            mark_mode       = 1'b0;
            boot            = 1'b0;
            tape_mark_record = 1'b0;
            active          = 1'b0;
            writing         = 1'b0;
            end_flag        = 1'b0;
            error_flag      = 1'b0;
            failures        = 0;
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_MEMORY_SIZE: memory_size     = value[MEM_SIZE_W-1:0];
                REG_TAPE_MARK:   tape_mark_code  = value[CHAR_W-1:0];
                REG_GROUP_MARK:  group_mark_code = value[CHAR_W-1:0];
                REG_WORD_MARK:   word_mark_code  = value[CHAR_W-1:0];
                REG_ALT_BLANK:   alt_blank_code  = value[CHAR_W-1:0];
                REG_BLANK:       blank_code      = value[CHAR_W-1:0];
                default: ;
            endcase
        endfunction

        // memory size clamped to 1 .. 2^ADDR_BITS
        function int unsigned usable_size();
            int unsigned s;
            s = 32'(memory_size);
            if (s > (1 << ADDR_BITS)) s = 1 << ADDR_BITS;
            if (s == 0) s = 1;
            return s;
        endfunction

        // step the address, true when it wraps to zero
        function bit advance_address();
            int unsigned a;
            a = 32'(address);
            a = a + 1;
            if (a >= usable_size()) begin
                address = '0;
                return 1'b1;
            end
            address = a[ADDR_BITS-1:0];
            return 1'b0;
        endfunction

        function void owe_result(bit wr, logic [ADDR_BITS-1:0] ad, logic [WORD_W-1:0] dat,
                                 bit tv, logic [CHAR_W-1:0] tch, logic [STATUS_W-1:0] st,
                                 bit lst);
            res_t r;
            r.mem_write  = wr;
            r.mem_addr   = ADDR_MAX'(ad);
            r.mem_data   = dat;
            r.tape_valid = tv;
            r.tape_out   = tch;
            r.status     = st;
            r.end_ind    = end_flag;
            r.err_ind    = error_flag;
            r.last       = lst;
            awaited.push_back(r);
        endfunction

        // work out the results of one accepted item
        function void note_item(transfer_item_t it);
            logic [WORD_W-1:0]   gm_wm;
            logic [CHAR_W-1:0]   t;
            logic [STATUS_W-1:0] st;
            logic [WORD_W-1:0]   dat;
            logic [ADDR_BITS-1:0] at;
            bit                  wr;
            gm_wm = {1'b1, group_mark_code};
            st    = ST_CONTINUE;
            dat   = '0;
            wr    = 1'b0;
            at    = address;

            // start of a read or a write transfer
            if (it.cmd == CMD_START_READ || it.cmd == CMD_START_WRITE) begin
                binary       = it.binary_mode;
                mark_mode    = it.word_mark_mode;
                boot         = it.boot_mode;
                address      = it.start_address;
                first_char   = 1'b1;
                mark_pending = 1'b0;
                active       = 1'b1;
                writing      = (it.cmd == CMD_START_WRITE);
                if (!writing) begin
                    tape_mark_record = it.record_is_tape_mark;
                    end_flag         = it.record_is_tape_mark;
                    error_flag       = it.record_in_error;
                end
                else begin
                    tape_mark_record = 1'b0;
                    end_flag         = 1'b0;
                    error_flag       = 1'b0;
                end
                if (address >= usable_size()) begin
                    address = '0;
                    active  = 1'b0;
                    st      = ST_WRAP;
                end
                owe_result(1'b0, address, '0, 1'b0, '0, st, 1'b1);
                return;
            end

            // tape character into memory
            if (it.cmd == CMD_TAPE_CHAR && active && !writing) begin
                t = it.tape_char[CHAR_W-1:0];
                if (first_char && !binary && t == tape_mark_code) end_flag = 1'b1;
                first_char = 1'b0;
                if (!boot && it.mem_word == gm_wm) begin
                    st     = advance_address() ? ST_WRAP : ST_GROUP_MARK;
                    active = 1'b0;
                    owe_result(1'b0, address, '0, 1'b0, '0, st, 1'b1);
                    return;
                end
                if (!binary && t == alt_blank_code) t = blank_code;
                if (mark_mode) begin
                    if (t == word_mark_code && !mark_pending) begin
                        mark_pending = 1'b1;
                    end
                    else begin
                        wr           = 1'b1;
                        dat          = {mark_pending, t};
                        mark_pending = 1'b0;
                    end
                end
                else begin
                    wr  = 1'b1;
                    dat = {it.mem_word[WORD_W-1], t};
                end
                if (!mark_pending && advance_address()) begin
                    st     = ST_WRAP;
                    active = 1'b0;
                end
                owe_result(wr, wr ? at : address, dat, 1'b0, '0, st, 1'b1);
                return;
            end

            // end of the read record: group mark stored unless a tape mark record or already in memory
            if (it.cmd == CMD_END_RECORD && active && !writing) begin
                active = 1'b0;
                if (tape_mark_record) begin
                    owe_result(1'b0, address, '0, 1'b0, '0, ST_DONE, 1'b1);
                    return;
                end
                if (it.mem_word != gm_wm) begin
                    wr  = 1'b1;
                    dat = mark_mode ? {1'b0, group_mark_code}
                                    : {it.mem_word[WORD_W-1], group_mark_code};
                end
                st = advance_address() ? ST_WRAP : ST_DONE;
                owe_result(wr, wr ? at : address, dat, 1'b0, '0, st, 1'b1);
                return;
            end

            // memory word onto tape
            if (it.cmd == CMD_MEM_WORD && active && writing) begin
                if (it.mem_word == gm_wm) begin
                    if (first_char) st = ST_EMPTY_WRITE;
                    else            st = advance_address() ? ST_WRAP : ST_DONE;
                    first_char = 1'b0;
                    active     = 1'b0;
                    owe_result(1'b0, address, '0, 1'b0, '0, st, 1'b1);
                    return;
                end
                first_char = 1'b0;
                if (it.mem_word[WORD_W-1] && mark_mode)
                    owe_result(1'b0, address, '0, 1'b1, word_mark_code, ST_CONTINUE, 1'b0);
                t = it.mem_word[CHAR_W-1:0];
                if (t == blank_code && !binary) t = alt_blank_code;
                if (advance_address()) begin
                    st     = ST_WRAP;
                    active = 1'b0;
                end
                owe_result(1'b0, address, '0, 1'b1, t, st, 1'b1);
                return;
            end

            // ignored item
            owe_result(1'b0, address, '0, 1'b0, '0, ST_CONTINUE, 1'b1);
        endfunction

        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v) begin
                $error("%s: expected %0d, actual %0d", name, want_v, got_v);
                failures++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (awaited.size() == 0) begin
                $error("result with none awaited: mem_addr %0d status %0d",
                       got.mem_addr, got.status);
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
            compare_field("mem_addr", 32'(want.mem_addr), 32'(got.mem_addr));
            compare_field("mem_data", 32'(want.mem_data), 32'(got.mem_data));
            compare_field("tape_valid", 32'(want.tape_valid), 32'(got.tape_valid));
            compare_field("tape_out", 32'(want.tape_out), 32'(got.tape_out));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("end_indicator", 32'(want.end_ind), 32'(got.end_ind));
            compare_field("error_indicator", 32'(want.err_ind), 32'(got.err_ind));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push;
    logic                  full;
    logic [CMD_W-1:0]      cmd;
    logic                  binary_mode;
    logic                  word_mark_mode;
    logic                  boot_mode;
    logic [ADDR_BITS-1:0]  start_address;
    logic                  record_is_tape_mark;
    logic                  record_in_error;
    logic [WORD_W-1:0]     tape_char;
    logic [WORD_W-1:0]     mem_word;
    logic                  empty;
    logic                  pop;
    logic                  mem_write;
    logic [ADDR_BITS-1:0]  mem_addr;
    logic [WORD_W-1:0]     mem_data;
    logic                  tape_valid;
    logic [CHAR_W-1:0]     tape_out;
    logic [STATUS_W-1:0]   status;
    logic                  end_indicator;
    logic                  error_indicator;
    logic                  last;

    char_transfer_tracker tracker = new();
    int  send_idle_pct = 14;
    int  recv_idle_pct = 79;
    bit  hold_off_request = 1'b0;
    int unsigned cycle_count = 0;

    tape_record_memory_transfer_top #(.ADDR_BITS(ADDR_BITS)) uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .push                (push),
        .full                (full),
        .cmd                 (cmd),
        .binary_mode         (binary_mode),
        .word_mark_mode      (word_mark_mode),
        .boot_mode           (boot_mode),
        .start_address       (start_address),
        .record_is_tape_mark (record_is_tape_mark),
        .record_in_error     (record_in_error),
        .tape_char           (tape_char),
        .mem_word            (mem_word),
        .empty               (empty),
        .pop                 (pop),
        .mem_write           (mem_write),
        .mem_addr            (mem_addr),
        .mem_data            (mem_data),
        .tape_valid          (tape_valid),
        .tape_out            (tape_out),
        .status              (status),
        .end_indicator       (end_indicator),
        .error_indicator     (error_indicator),
        .last                (last)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic transfer_item_t item_of(logic [CMD_W-1:0] c, logic bin, logic wmm,
                                               logic bt, logic [ADDR_BITS-1:0] sa,
                                               logic tm, logic err, logic [WORD_W-1:0] tc,
                                               logic [WORD_W-1:0] mw);
        transfer_item_t it;
        it.cmd                 = c;
        it.binary_mode         = bin;
        it.word_mark_mode      = wmm;
        it.boot_mode           = bt;
        it.start_address       = sa;
        it.record_is_tape_mark = tm;
        it.record_in_error     = err;
        it.tape_char           = tc;
        it.mem_word            = mw;
        return it;
    endfunction

    // transfers seen on both ports, sampled before the edge takes effect
    always @(posedge clk)
    begin : port_monitor
        res_t seen;
        if (rst_n === 1'b1) begin
            if (push && !full)
                tracker.note_item(item_of(cmd, binary_mode, word_mark_mode, boot_mode,
                                          start_address, record_is_tape_mark,
                                          record_in_error, tape_char, mem_word));
            if (pop && !empty) begin
                seen.mem_write  = mem_write;
                seen.mem_addr   = ADDR_MAX'(mem_addr);
                seen.mem_data   = mem_data;
                seen.tape_valid = tape_valid;
                seen.tape_out   = tape_out;
                seen.status     = status;
                seen.end_ind    = end_indicator;
                seen.err_ind    = error_indicator;
                seen.last       = last;
                tracker.check_result(seen);
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : result_taker
        pop <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // run limit
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL tape_record_memory_transfer_top");
        $finish;
    end

    // offer one item until taken, then maybe leave a gap
    task automatic send_item(input transfer_item_t it);
        cmd                 <= it.cmd;
        binary_mode         <= it.binary_mode;
        word_mark_mode      <= it.word_mark_mode;
        boot_mode           <= it.boot_mode;
        start_address       <= it.start_address;
        record_is_tape_mark <= it.record_is_tape_mark;
        record_in_error     <= it.record_in_error;
        tape_char           <= it.tape_char;
        mem_word            <= it.mem_word;
        push                <= 1'b1;
        do @(posedge clk); while (full);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_start(input logic [CMD_W-1:0] c, input logic bin, input logic wmm,
                              input logic bt, input logic [ADDR_BITS-1:0] sa,
                              input logic tm, input logic err);
        send_item(item_of(c, bin, wmm, bt, sa, tm, err, '0, '0));
    endtask

    task automatic send_char(input logic [CMD_W-1:0] c, input logic [WORD_W-1:0] tc,
                             input logic [WORD_W-1:0] mw);
        send_item(item_of(c, 1'b0, 1'b0, 1'b0, '0, 1'b0, 1'b0, tc, mw));
    endtask

    // stop offering, wait for every owed result, then let the pipeline empty
    task automatic settle();
        push <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write: setup phase, access phase, then idle
    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        tracker.set_register(idx, value);
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 9))
            0: return tracker.tape_mark_code;
            1: return tracker.group_mark_code;
            2: return tracker.word_mark_code;
            3: return tracker.alt_blank_code;
            4: return tracker.blank_code;
            default: return CHAR_W'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_mem_word();
        if ($urandom_range(0, 9) == 0) return {1'b1, tracker.group_mark_code};
        return {1'($urandom_range(0, 1)), pick_char()};
    endfunction

    // mostly inside memory, often near the top, sometimes beyond it
    function automatic logic [ADDR_BITS-1:0] pick_start();
        int unsigned top;
        top = tracker.usable_size() - 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return ADDR_BITS'($urandom_range(0, top));
            6, 7: return ADDR_BITS'(top - $urandom_range(0, (top < 8) ? top : 8));
            8: return ADDR_BITS'($urandom);
            default: return $urandom_range(0, 1) ? {ADDR_BITS{1'b1}} : {ADDR_BITS{1'b0}};
        endcase
    endfunction

    task automatic send_read_record(inout int sent);
        int n_chars;
        n_chars = $urandom_range(0, 12);
        send_item(item_of(CMD_START_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 3) == 0), pick_start(),
                          ($urandom_range(0, 6) == 0), ($urandom_range(0, 4) == 0),
                          WORD_W'($urandom), WORD_W'($urandom)));
        repeat (n_chars)
            send_char(CMD_TAPE_CHAR, {1'($urandom_range(0, 1)), pick_char()}, pick_mem_word());
        if ($urandom_range(0, 9) != 0)
            send_char(CMD_END_RECORD, WORD_W'($urandom), pick_mem_word());
        sent += n_chars + 2;
    endtask

    task automatic send_write_record(inout int sent);
        int n_words;
        logic [WORD_W-1:0] gm_wm;
        n_words = $urandom_range(0, 10);
        send_item(item_of(CMD_START_WRITE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), pick_start(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), WORD_W'($urandom), WORD_W'($urandom)));
        gm_wm = {1'b1, tracker.group_mark_code};
        repeat (n_words)
            send_char(CMD_MEM_WORD, WORD_W'($urandom), pick_mem_word());
        if ($urandom_range(0, 6) != 0)
            send_char(CMD_MEM_WORD, WORD_W'($urandom), gm_wm);
        sent += n_words + 2;
    endtask

    // well-formed records with random content, some noise in between
    task automatic run_records(input int target);
        int sent;
        int pick;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_read_record(sent);
            else if (pick < 88)
                send_write_record(sent);
            else
                send_item(item_of(CMD_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  ADDR_BITS'($urandom), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), WORD_W'($urandom),
                                  WORD_W'($urandom)));
        end
    endtask

    task automatic configure_segment(input int seg);
        logic [31:0] size;
        logic [5:0]  codes [6];
        for (int i = 0; i < 6; i++) codes[i] = 6'($urandom_range(0, 63));
        case (seg)
            0: begin
                size     = 32'(MEM_SIZE_RST);
                codes[1] = TAPE_MARK_RST;
                codes[2] = GROUP_MARK_RST;
                codes[3] = WORD_MARK_RST;
                codes[4] = ALT_BLANK_RST;
                codes[5] = BLANK_RST;
            end
            1: begin
                size = 1;
                for (int i = 1; i < 6; i++) codes[i] = 6'd0;
            end
            2: size = 0;
            3: begin
                size = 16384;
                for (int i = 1; i < 6; i++) codes[i] = 6'd63;
            end
            4: size = 32767;
            5: size = 37;
            6: size = 16383;
            7: size = 200;
            default: size = 5;
        endcase
        write_register(REG_MEMORY_SIZE, size);
        write_register(REG_TAPE_MARK, {26'd0, codes[1]});
        write_register(REG_GROUP_MARK, {26'd0, codes[2]});
        write_register(REG_WORD_MARK, {26'd0, codes[3]});
        write_register(REG_ALT_BLANK, {26'd0, codes[4]});
        write_register(REG_BLANK, {26'd0, codes[5]});
    endtask

    // directed cases on the reset register values
    task automatic run_directed();
        // tape mark record with error, tape mark as first character
        send_start(CMD_START_READ, 1'b0, 1'b0, 1'b0, '0, 1'b1, 1'b1);
        send_char(CMD_TAPE_CHAR, 7'h0F, 7'h00);
        send_char(CMD_END_RECORD, 7'h00, 7'h00);
        // start beyond memory size, then a character while idle
        send_start(CMD_START_READ, 1'b0, 1'b1, 1'b0, {ADDR_BITS{1'b1}}, 1'b0, 1'b0);
        send_char(CMD_TAPE_CHAR, 7'h7F, 7'h7F);
        // word-mark mode merge, alternate blank with parity, wrap at the top
        send_start(CMD_START_READ, 1'b0, 1'b1, 1'b0, 14'd15998, 1'b0, 1'b0);
        send_char(CMD_TAPE_CHAR, 7'h1D, 7'h00);
        send_char(CMD_TAPE_CHAR, 7'h50, 7'h00);
        send_char(CMD_TAPE_CHAR, 7'h7F, 7'h40);
        // group mark with word mark in memory stops the read
        send_start(CMD_START_READ, 1'b0, 1'b0, 1'b0, 14'd100, 1'b0, 1'b0);
        send_char(CMD_TAPE_CHAR, 7'h22, 7'h7F);
        // boot mode goes past it, end of record over a group mark
        send_start(CMD_START_READ, 1'b0, 1'b0, 1'b1, 14'd200, 1'b0, 1'b0);
        send_char(CMD_TAPE_CHAR, 7'h00, 7'h7F);
        send_char(CMD_END_RECORD, 7'h00, 7'h7F);
        // binary read: no tape mark check, no blank mapping
        send_start(CMD_START_READ, 1'b1, 1'b0, 1'b0, 14'd300, 1'b0, 1'b0);
        send_char(CMD_TAPE_CHAR, 7'h0F, 7'h45);
        send_char(CMD_TAPE_CHAR, 7'h10, 7'h45);
        send_char(CMD_END_RECORD, 7'h00, 7'h45);
        // empty write
        send_start(CMD_START_WRITE, 1'b0, 1'b1, 1'b0, '0, 1'b0, 1'b0);
        send_char(CMD_MEM_WORD, 7'h00, 7'h7F);
        // write with a word-mark character and a blank, ended by group mark
        send_start(CMD_START_WRITE, 1'b0, 1'b1, 1'b0, 14'd400, 1'b0, 1'b0);
        send_char(CMD_MEM_WORD, 7'h00, 7'h40);
        send_char(CMD_TAPE_CHAR, 7'h05, 7'h23);
        send_char(CMD_MEM_WORD, 7'h00, 7'h7F);
        // binary write wrapping at the top
        send_start(CMD_START_WRITE, 1'b1, 1'b0, 1'b0, 14'd15999, 1'b0, 1'b0);
        send_char(CMD_MEM_WORD, 7'h00, 7'h00);
        // commands with no meaning
        send_char(CMD_RESERVED_FIRST, 7'h00, 7'h00);
        send_item(item_of(CMD_RESERVED_LAST, 1'b1, 1'b1, 1'b1, {ADDR_BITS{1'b1}},
                          1'b1, 1'b1, 7'h7F, 7'h7F));
    endtask

    // main sequence
    initial
    begin : stimulus
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        push                <= 1'b0;
        cmd                 <= '0;
        binary_mode         <= 1'b0;
        word_mark_mode      <= 1'b0;
        boot_mode           <= 1'b0;
        start_address       <= '0;
        record_is_tape_mark <= 1'b0;
        record_in_error     <= 1'b0;
        tape_char           <= '0;
        mem_word            <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            if (seg < 3) begin
                send_idle_pct = 14;
                recv_idle_pct = 79;
            end
            else if (seg < 6) begin
                send_idle_pct = 79;
                recv_idle_pct = 14;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure_segment(seg);
            // long receiver stall while items keep coming
            if (seg == 7) hold_off_request = 1'b1;
            run_records(RECORD_ITEMS);
        end

        settle();
        if (tracker.failures == 0)
            $display("PASS tape_record_memory_transfer_top");
        else
            $display("FAIL tape_record_memory_transfer_top");
        $finish;
    end

endmodule
